// ===== src/sgb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgb_pkg: shared types and constants of the separable Gaussian blur
// Field widths, register indexes and the control flags passed front to back.
// ----------------------------------------------------------------------------
package sgb_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_TAPS_DEF  = 8;

  localparam int PIX_W   = 8;
  localparam int COEF_W  = 16;
  localparam int LW_W    = 11;
  localparam int TAPS_W  = 4;
  localparam int ROW_W   = 16;
  localparam int CFG_A_W = 3;
  localparam int VP_W    = COEF_W + PIX_W;   // vertical product
  localparam int VSUM_W  = 27;               // vertical sum
  localparam int HP_W    = COEF_W + VSUM_W;  // horizontal product
  localparam int HSUM_W  = HP_W + 3;         // up to eight products
  localparam int SHIFT   = 30;

  typedef enum logic [CFG_A_W-1:0] {
    REG_LINE_WIDTH  = 3'd0,
    REG_KERNEL_TAPS = 3'd1,
    REG_COEF_OUTER  = 3'd2,
    REG_COEF_SECOND = 3'd3,
    REG_COEF_THIRD  = 3'd4,
    REG_COEF_FOURTH = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic has_v;
    logic has_out;
    logic eol;
    logic fend;
  } sgb_flags_t;

  localparam int FLAGS_W = $bits(sgb_flags_t);

endpackage
`default_nettype wire

// ===== src/sgb_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgb_queue: short FIFO between the front and back parts
// Register based, one push (while not full) and one pop (while not empty) per cycle.
// ----------------------------------------------------------------------------
module sgb_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              not_full,
  input  wire logic         pop,
  output logic              not_empty,
  output logic [W-1:0]      pop_data
);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign not_full  = cnt_r != CW'(DEPTH);
  assign not_empty = cnt_r != '0;
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("queue count overflow");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count not advanced on push");

endmodule
`default_nettype wire

// ===== src/sgb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgb_front: pixel intake, raster position and line store
// Tracks column and row, reads and rewrites the per-column line history,
// and hands pixels with a full vertical window to the back part.
// ----------------------------------------------------------------------------
module sgb_front #(
  parameter int MAX_WIDTH = sgb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_TAPS  = sgb_pkg::MAX_TAPS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [sgb_pkg::PIX_W-1:0]          in_pix,
  input  wire logic                               in_lend,
  input  wire logic                               in_fend,
  input  wire logic [sgb_pkg::LW_W-1:0]           line_width,
  input  wire logic [sgb_pkg::TAPS_W-1:0]         taps_m1,
  output logic                                    q_push,
  input  wire logic                               q_not_full,
  output logic [MAX_TAPS-1:0][sgb_pkg::PIX_W-1:0] q_pix,
  output sgb_pkg::sgb_flags_t                     q_flags
);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int DW = (MAX_TAPS - 1) * sgb_pkg::PIX_W;

  logic [DW-1:0] mem [MAX_WIDTH];

  logic [CW-1:0]             col_r;
  logic [sgb_pkg::ROW_W-1:0] row_r;
  logic                      s1_v_r;
  logic [AW-1:0]             s1_x_r;
  logic [sgb_pkg::PIX_W-1:0] s1_pix_r;
  sgb_pkg::sgb_flags_t       s1_fl_r;
  logic                      s1_byp_r;
  logic [DW-1:0]             s1_bypd_r, rd_r;

  logic [15:0]         w16, wm1, x16;
  logic [AW-1:0]       x_now;
  logic                accept, s1_adv;
  logic [DW-1:0]       old_word, new_word;
  sgb_pkg::sgb_flags_t fl_nxt;

  always_comb begin
    w16 = {5'd0, line_width};
    if (w16 == 16'd0) begin
      w16 = 16'd1;
    end else if (w16 > 16'(MAX_WIDTH)) begin
      w16 = 16'(MAX_WIDTH);
    end
    wm1 = w16 - 16'd1;
    x16 = (16'(col_r) >= w16) ? wm1 : 16'(col_r);
    x_now = x16[AW-1:0];
    fl_nxt.has_v   = row_r >= 16'(taps_m1);
    fl_nxt.has_out = fl_nxt.has_v && (x16 >= 16'(taps_m1));
    fl_nxt.fend    = in_fend;
    fl_nxt.eol     = in_lend || in_fend || (x16 == wm1);
  end

  assign s1_adv   = s1_v_r && (!s1_fl_r.has_v || q_not_full);
  assign in_ready = !s1_v_r || s1_adv;
  assign accept   = in_valid && in_ready;
  assign q_push   = s1_v_r && s1_fl_r.has_v && q_not_full;
  assign q_flags  = s1_fl_r;

  // shift the column history: oldest line drops, this pixel becomes newest
  assign old_word = s1_byp_r ? s1_bypd_r : rd_r;
  assign new_word = (old_word >> sgb_pkg::PIX_W) |
                    (DW'(s1_pix_r) << (DW - sgb_pkg::PIX_W));

  always_comb begin
    for (int j = 0; j < MAX_TAPS - 1; j++) begin
      q_pix[j] = old_word[j*sgb_pkg::PIX_W +: sgb_pkg::PIX_W];
    end
    q_pix[MAX_TAPS-1] = s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= mem[x_now];
    end
    if (s1_adv) begin
      mem[s1_x_r] <= new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x_r    <= x_now;
      s1_pix_r  <= in_pix;
      s1_fl_r   <= fl_nxt;
      s1_bypd_r <= new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      s1_v_r   <= 1'b0;
      s1_byp_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_r <= 1'b1;
        // forward the word still being written to the same column
        s1_byp_r <= s1_adv && (s1_x_r == x_now);
        if (fl_nxt.fend) begin
          col_r <= '0;
          row_r <= '0;
        end else if (fl_nxt.eol) begin
          col_r <= '0;
          if (row_r != '1) begin
            row_r <= row_r + 1'b1;
          end
        end else begin
          col_r <= CW'(x16 + 16'd1);
        end
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_adv |=> s1_v_r && $stable(s1_x_r))
    else $error("stalled item lost its column");
  a_frame: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_fend |=> col_r == '0 && row_r == '0)
    else $error("frame end did not rewind position");

endmodule
`default_nettype wire

// ===== src/sgb_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sgb_back: vertical and horizontal filter datapath
// Weighs the column window, keeps the recent vertical sums of the line,
// weighs those, then truncates and saturates into the output register.
// ----------------------------------------------------------------------------
module sgb_back #(
  parameter int MAX_TAPS = sgb_pkg::MAX_TAPS_DEF
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      q_valid,
  output logic                                           q_pop,
  input  wire logic [MAX_TAPS-1:0][sgb_pkg::PIX_W-1:0]   q_pix,
  input  wire sgb_pkg::sgb_flags_t                       q_flags,
  input  wire logic [MAX_TAPS-1:0][sgb_pkg::COEF_W-1:0]  wt,
  output logic                                           out_valid,
  input  wire logic                                      out_ready,
  output logic [sgb_pkg::PIX_W-1:0]                      out_pix,
  output logic                                           out_row_last,
  output logic                                           out_frame_last
);
  logic                                        en;
  logic                                        v1_v_r, c_v_r, h1_v_r, o_v_r;
  sgb_pkg::sgb_flags_t                         v1_fl_r, c_fl_r, h1_fl_r;
  logic [MAX_TAPS-1:0][sgb_pkg::VP_W-1:0]      vp_r;
  logic [MAX_TAPS-1:0][sgb_pkg::VSUM_W-1:0]    colsum_r;
  logic [MAX_TAPS-1:0][sgb_pkg::HP_W-1:0]      hp_r;
  logic [sgb_pkg::VSUM_W-1:0]                  vsum;
  logic [sgb_pkg::HSUM_W-1:0]                  hsum;
  logic [sgb_pkg::HSUM_W-sgb_pkg::SHIFT-1:0]   hsh;
  logic [sgb_pkg::PIX_W-1:0]                   pix_sat, o_pix_r;
  logic                                        o_rl_r, o_fl_r;

  assign en    = !o_v_r || out_ready;
  assign q_pop = en && q_valid;

  always_comb begin
    vsum = '0;
    for (int j = 0; j < MAX_TAPS; j++) begin
      vsum = vsum + sgb_pkg::VSUM_W'(vp_r[j]);
    end
    hsum = '0;
    for (int j = 0; j < MAX_TAPS; j++) begin
      hsum = hsum + sgb_pkg::HSUM_W'(hp_r[j]);
    end
    hsh = hsum[sgb_pkg::HSUM_W-1:sgb_pkg::SHIFT];
    pix_sat = (hsh > (sgb_pkg::HSUM_W-sgb_pkg::SHIFT)'(255)) ? '1 : hsh[sgb_pkg::PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1_fl_r <= q_flags;
      c_fl_r  <= v1_fl_r;
      h1_fl_r <= c_fl_r;
      o_pix_r <= pix_sat;
      o_rl_r  <= h1_fl_r.eol;
      o_fl_r  <= h1_fl_r.fend;
      for (int j = 0; j < MAX_TAPS; j++) begin
        vp_r[j] <= sgb_pkg::VP_W'(wt[j] * q_pix[j]);
        hp_r[j] <= sgb_pkg::HP_W'(wt[j] * colsum_r[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_v_r   <= 1'b0;
      c_v_r    <= 1'b0;
      h1_v_r   <= 1'b0;
      o_v_r    <= 1'b0;
      colsum_r <= '0;
    end else if (en) begin
      v1_v_r <= q_valid;
      c_v_r  <= v1_v_r && v1_fl_r.has_out;
      h1_v_r <= c_v_r;
      o_v_r  <= h1_v_r;
      if (v1_v_r) begin
        // newest vertical sum enters at the top lane
        for (int j = 0; j < MAX_TAPS - 1; j++) begin
          colsum_r[j] <= colsum_r[j+1];
        end
        colsum_r[MAX_TAPS-1] <= vsum;
      end
    end
  end

  assign out_valid      = o_v_r;
  assign out_pix        = o_pix_r;
  assign out_row_last   = o_rl_r;
  assign out_frame_last = o_fl_r;

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(o_v_r) |-> $past(h1_v_r)) else $error("result without source item");

endmodule
`default_nettype wire

// ===== src/separable_gaussian_blur.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// separable_gaussian_blur: valid-mode separable Gaussian filter, 8-bit gray
// Usage:
//   in_*  : raster pixels; tdata = pixel, tlast = line end, tuser = frame end.
//   out_* : filtered pixels of full n-by-n windows only, (W-n+1)x(H-n+1) per
//           frame; tlast = last of output row, tuser = last of frame.
//   cfg_* : write line width, tap count and four Q1.15 weights while idle.
// Throughput is one pixel per clock while the receiver does not stall. From
// input transfer to output valid a pixel passes, in order: the line store read
// at the transfer edge, then queue, vertical multiply, vertical sum, horizontal
// multiply, horizontal sum with saturation.
// Pixels without a full vertical window only update the line store and give
// no output. A four-entry queue separates the line store side from the
// multiplier pipeline; when the receiver stalls the pipeline holds, the
// queue fills and then in_tready drops.
// Reset (synchronous, rst_n low) restores the default registers and clears
// position and sums. The line store is not cleared: lines above the first
// are read only after the first lines of a frame have written them.
// ----------------------------------------------------------------------------
module separable_gaussian_blur #(
  parameter int MAX_WIDTH = sgb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_TAPS  = sgb_pkg::MAX_TAPS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [7:0]                    in_tdata,   // [7:0] pixel_in
  input  wire logic                          in_tlast,   // line_end
  input  wire logic                          in_tuser,   // [0] frame_end
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [7:0]                         out_tdata,  // [7:0] pixel_out
  output logic                               out_tlast,  // row_last
  output logic                               out_tuser,  // [0] frame_last
  input  wire logic                          cfg_we,
  input  wire logic [sgb_pkg::CFG_A_W-1:0]   cfg_addr,
  input  wire logic [sgb_pkg::COEF_W-1:0]    cfg_wdata
);
  localparam int QW = MAX_TAPS * sgb_pkg::PIX_W + sgb_pkg::FLAGS_W;

  logic [sgb_pkg::LW_W-1:0]                    lw_r;
  logic [sgb_pkg::TAPS_W-1:0]                  kt_r, n_eff, taps_m1;
  logic [3:0][sgb_pkg::COEF_W-1:0]             coef_r;
  logic [MAX_TAPS-1:0][sgb_pkg::COEF_W-1:0]    wt_r, wt_nxt;

  logic                                        q_push, q_not_full, q_not_empty, q_pop;
  logic [MAX_TAPS-1:0][sgb_pkg::PIX_W-1:0]     f_pix, b_pix;
  sgb_pkg::sgb_flags_t                         f_fl, b_fl;
  logic [QW-1:0]                               q_wr, q_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r      <= sgb_pkg::LW_W'(640);
      kt_r      <= sgb_pkg::TAPS_W'(5);
      coef_r[0] <= 16'd2000;
      coef_r[1] <= 16'd8000;
      coef_r[2] <= 16'd12768;
      coef_r[3] <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_addr)
        sgb_pkg::REG_LINE_WIDTH:  lw_r      <= cfg_wdata[sgb_pkg::LW_W-1:0];
        sgb_pkg::REG_KERNEL_TAPS: kt_r      <= cfg_wdata[sgb_pkg::TAPS_W-1:0];
        sgb_pkg::REG_COEF_OUTER:  coef_r[0] <= cfg_wdata;
        sgb_pkg::REG_COEF_SECOND: coef_r[1] <= cfg_wdata;
        sgb_pkg::REG_COEF_THIRD:  coef_r[2] <= cfg_wdata;
        sgb_pkg::REG_COEF_FOURTH: coef_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [sgb_pkg::TAPS_W-1:0] off, k, m, i;
    n_eff = kt_r;
    if (n_eff == '0) begin
      n_eff = sgb_pkg::TAPS_W'(1);
    end else if (n_eff > sgb_pkg::TAPS_W'(MAX_TAPS)) begin
      n_eff = sgb_pkg::TAPS_W'(MAX_TAPS);
    end
    taps_m1 = n_eff - 1'b1;
    off = sgb_pkg::TAPS_W'(MAX_TAPS) - n_eff;
    // lanes below the window get weight zero; symmetric weights inside it
    for (int j = 0; j < MAX_TAPS; j++) begin
      k = sgb_pkg::TAPS_W'(j) - off;
      m = taps_m1 - k;
      i = (k < m) ? k : m;
      wt_nxt[j] = (sgb_pkg::TAPS_W'(j) >= off) ? coef_r[i[1:0]] : '0;
    end
  end

  always_ff @(posedge clk) begin
    wt_r <= wt_nxt;
  end

  sgb_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_TAPS(MAX_TAPS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_pix     (in_tdata),
    .in_lend    (in_tlast),
    .in_fend    (in_tuser),
    .line_width (lw_r),
    .taps_m1    (taps_m1),
    .q_push     (q_push),
    .q_not_full (q_not_full),
    .q_pix      (f_pix),
    .q_flags    (f_fl)
  );

  assign q_wr = {f_fl, f_pix};
  assign {b_fl, b_pix} = q_rd;

  sgb_queue #(.W(QW), .DEPTH(4)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wr),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_rd)
  );

  sgb_back #(.MAX_TAPS(MAX_TAPS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_not_empty),
    .q_pop          (q_pop),
    .q_pix          (b_pix),
    .q_flags        (b_fl),
    .wt             (wt_r),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_pix        (out_tdata),
    .out_row_last   (out_tlast),
    .out_frame_last (out_tuser)
  );

endmodule
`default_nettype wire

// ===== dv/separable_gaussian_blur_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// separable_gaussian_blur_chk: prediction and comparison for the blur block
// Watches the config port and both stream channels, computes the filtered
// pixel of every full window in its own copy of the filter state and checks
// each output transfer against the oldest pending pixel.
// ----------------------------------------------------------------------------
module separable_gaussian_blur_chk (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [7:0]                  in_tdata,
  input  logic                        in_tlast,
  input  logic                        in_tuser,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [7:0]                  out_tdata,
  input  logic                        out_tlast,
  input  logic                        out_tuser,
  input  logic                        cfg_we,
  input  logic [sgb_pkg::CFG_A_W-1:0] cfg_addr,
  input  logic [sgb_pkg::COEF_W-1:0]  cfg_wdata,
  output int                          errors,
  output int                          pending
);

  typedef struct packed {
    logic [7:0] pix;
    logic       row_last;
    logic       frame_last;
  } blur_px_t;

  blur_px_t                   blurred_q[$];
  logic [7:0]                 line_px [0:sgb_pkg::MAX_WIDTH_DEF-1][0:sgb_pkg::MAX_TAPS_DEF-2];
  logic [sgb_pkg::VSUM_W-1:0] col_sums [0:sgb_pkg::MAX_TAPS_DEF-1];
  int unsigned                col_cnt, row_cnt, width_reg, taps_reg;
  logic [sgb_pkg::COEF_W-1:0] wt [0:3];
  int                         mism;

  assign pending = blurred_q.size();
  assign errors  = mism;

  function automatic logic [63:0] tap_wt(int unsigned k, int unsigned n);
    int unsigned m, i;
    m = n - 1 - k;
    i = (k < m) ? k : m;
    return 64'(wt[i & 3]);
  endfunction

  task automatic take_pixel(logic [7:0] p, logic lend, logic fend);
    int unsigned n, w, x, k, mt, mw;
    logic        eol;
    logic [63:0] v, h;
    blur_px_t    e;
    mt = sgb_pkg::MAX_TAPS_DEF;
    mw = sgb_pkg::MAX_WIDTH_DEF;
    n = (taps_reg == 0) ? 1 : ((taps_reg > mt) ? mt : taps_reg);
    w = (width_reg == 0) ? 1 : ((width_reg > mw) ? mw : width_reg);
    x = (col_cnt >= w) ? w - 1 : col_cnt;
    eol = lend || fend || (x + 1 >= w);
    if (row_cnt >= n - 1) begin
      v = 0;
      for (k = 0; k + 1 < n; k++)
        v += tap_wt(k, n) * 64'(line_px[x][mt - n + k]);
      v += tap_wt(n - 1, n) * 64'(p);
      for (k = 0; k + 1 < mt; k++) col_sums[k] = col_sums[k + 1];
      col_sums[mt - 1] = v[sgb_pkg::VSUM_W-1:0];
      if (x >= n - 1) begin
        h = 0;
        for (k = 0; k < n; k++)
          h += tap_wt(k, n) * 64'(col_sums[mt - n + k]);
        h = h >> sgb_pkg::SHIFT;
        e.pix        = (h > 255) ? 8'd255 : h[7:0];
        e.row_last   = eol;
        e.frame_last = fend;
        blurred_q.push_back(e);
      end
    end
    // shift the newest pixel into this column's history
    for (k = 0; k + 1 < mt - 1; k++) line_px[x][k] = line_px[x][k + 1];
    line_px[x][mt - 2] = p;
    if (fend) begin
      col_cnt = 0;
      row_cnt = 0;
    end else if (eol) begin
      col_cnt = 0;
      if (row_cnt < 16'hFFFF) row_cnt++;
    end else begin
      col_cnt = x + 1;
    end
  endtask

  initial mism = 0;

  always @(posedge clk) begin
    blurred_q_t: begin
      blur_px_t got, want;
      if (!rst_n) begin
        width_reg = 640;
        taps_reg  = 5;
        wt[0] = 16'd2000;
        wt[1] = 16'd8000;
        wt[2] = 16'd12768;
        wt[3] = 16'd0;
        for (int k = 0; k < sgb_pkg::MAX_TAPS_DEF; k++) col_sums[k] = '0;
        col_cnt = 0;
        row_cnt = 0;
        blurred_q.delete();
      end else begin
        if (cfg_we) begin
          case (sgb_pkg::reg_idx_t'(cfg_addr))
            sgb_pkg::REG_LINE_WIDTH:  width_reg = cfg_wdata[sgb_pkg::LW_W-1:0];
            sgb_pkg::REG_KERNEL_TAPS: taps_reg  = cfg_wdata[sgb_pkg::TAPS_W-1:0];
            sgb_pkg::REG_COEF_OUTER:  wt[0] = cfg_wdata;
            sgb_pkg::REG_COEF_SECOND: wt[1] = cfg_wdata;
            sgb_pkg::REG_COEF_THIRD:  wt[2] = cfg_wdata;
            sgb_pkg::REG_COEF_FOURTH: wt[3] = cfg_wdata;
            default: ;
          endcase
        end
        if (in_tvalid && in_tready) take_pixel(in_tdata, in_tlast, in_tuser);
        if (out_tvalid && out_tready) begin
          got = {out_tdata, out_tlast, out_tuser};
          if (blurred_q.size() == 0) begin
            mism++;
            if (mism <= 10)
              $display("%t unexpected output: pix=%0d row_last=%0b frame_last=%0b",
                       $realtime, got.pix, got.row_last, got.frame_last);
          end else begin
            want = blurred_q.pop_front();
            if (got.pix != want.pix || got.row_last != want.row_last ||
                got.frame_last != want.frame_last) begin
              mism++;
              if (mism <= 10)
                $display("%t mismatch: pix exp %0d got %0d, row_last exp %0b got %0b, %s",
                         $realtime, want.pix, got.pix, want.row_last, got.row_last,
                         $sformatf("frame_last exp %0b got %0b",
                                   want.frame_last, got.frame_last));
            end
          end
        end
      end
    end
  end

endmodule

// ===== dv/separable_gaussian_blur_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// separable_gaussian_blur_tb: stimulus and verdict for the blur block
// Drives raster frames under a series of register settings, with random
// gaps on both channels and one long output stall; the checker beside the
// block predicts every output pixel and counts mismatches.
// ----------------------------------------------------------------------------
module separable_gaussian_blur_tb;

  localparam int LIMIT = 1000000;

  logic                        clk;
  logic                        rst_n;
  logic                        in_tvalid, in_tready, in_tlast, in_tuser;
  logic [7:0]                  in_tdata;
  logic                        out_tvalid, out_tready, out_tlast, out_tuser;
  logic [7:0]                  out_tdata;
  logic                        cfg_we;
  logic [sgb_pkg::CFG_A_W-1:0] cfg_addr;
  logic [sgb_pkg::COEF_W-1:0]  cfg_wdata;
  int                          errors, pending;

  int          cycles, items, cur_w, cur_n;
  int          col_writes [0:sgb_pkg::MAX_WIDTH_DEF-1];
  bit          quiet, long_done;

  separable_gaussian_blur dut (.*);

  separable_gaussian_blur_chk chk (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] pick_pix();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // first column whose history is too short for a full vertical window
  function automatic int window_span();
    for (int x = 0; x < cur_w; x++)
      if (col_writes[x] < cur_n - 1) return x;
    return cur_w;
  endfunction

  // receiver: random stalls, plus one long hold-off to back up the block
  initial begin
    int g;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!long_done && items > 1300) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        long_done = 1;
      end
      out_tready <= 1'b1;
      repeat (quiet ? 1 : $urandom_range(1, 8)) @(posedge clk);
      g = pick_gap();
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  task automatic send_px(logic [7:0] p, logic lend, logic fend, int x);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    in_tlast  <= lend;
    in_tuser  <= fend;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (col_writes[x] < sgb_pkg::MAX_TAPS_DEF - 1) col_writes[x]++;
    items++;
  endtask

  task automatic send_frame(int rows, int base_len, bit ragged);
    int  len, span;
    bit  last, fend, lend;
    for (int r = 0; r < rows; r++) begin
      len = base_len;
      if (ragged && $urandom_range(0, 4) == 0)
        len = $urandom_range(1, (cur_w < 24) ? cur_w : 24);
      if (r >= cur_n - 1) begin
        span = window_span();
        if (len > span) len = span;
      end
      for (int x = 0; x < len; x++) begin
        last = (x == len - 1);
        fend = last && (r == rows - 1);
        if (!last) lend = 1'b0;
        else if (fend || len == cur_w) lend = 1'($urandom);
        else lend = 1'b1;
        send_px(pick_pix(), lend, fend, x);
      end
    end
  endtask

  task automatic set_regs(int w_raw, int n_raw, int c0, int c1, int c2, int c3);
    sgb_pkg::reg_idx_t idx [6];
    int                val [6];
    idx = '{sgb_pkg::REG_LINE_WIDTH, sgb_pkg::REG_KERNEL_TAPS, sgb_pkg::REG_COEF_OUTER,
            sgb_pkg::REG_COEF_SECOND, sgb_pkg::REG_COEF_THIRD, sgb_pkg::REG_COEF_FOURTH};
    val = '{w_raw, n_raw, c0, c1, c2, c3};
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= idx[i];
      cfg_wdata <= sgb_pkg::COEF_W'(val[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_w = (w_raw & 11'h7FF) == 0 ? 1 :
            ((w_raw & 11'h7FF) > sgb_pkg::MAX_WIDTH_DEF ? sgb_pkg::MAX_WIDTH_DEF :
             (w_raw & 11'h7FF));
    cur_n = (n_raw & 4'hF) == 0 ? 1 :
            ((n_raw & 4'hF) > sgb_pkg::MAX_TAPS_DEF ? sgb_pkg::MAX_TAPS_DEF : (n_raw & 4'hF));
  endtask

  // drain: no transfer in flight, then allow for the block's pipeline
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic int pick_coef();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 65535;
      2: return $urandom_range(0, 65535);
      default: return $urandom_range(0, 20000);
    endcase
  endfunction

  initial begin
    int w_raw, n_raw, r;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    in_tuser  = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = sgb_pkg::REG_LINE_WIDTH;
    cfg_wdata = '0;
    cycles = 0;
    items  = 0;
    quiet  = 0;
    long_done = 0;
    cur_w = 640;
    cur_n = 5;
    for (int x = 0; x < sgb_pkg::MAX_WIDTH_DEF; x++) col_writes[x] = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: one full 5x5 window
    send_frame(5, 5, 0);
    wait_idle();

    // zero taps and zero width act as one; full-scale weights saturate
    set_regs(0, 0, 65535, 65535, 65535, 65535);
    send_frame(4, 1, 0);
    wait_idle();

    // width beyond the maximum: line ends on its own at the last column
    set_regs(2047, 1, 32768, 0, 0, 0);
    quiet = 1;
    for (int x = 0; x < sgb_pkg::MAX_WIDTH_DEF; x++) send_px(pick_pix(), 1'b0, 1'b0, x);
    send_px(pick_pix(), 1'b0, 1'b1, 0);
    quiet = 0;
    wait_idle();

    // taps beyond the maximum use all eight
    set_regs(9, 15, pick_coef(), pick_coef(), pick_coef(), pick_coef());
    send_frame(9, 9, 0);
    wait_idle();

    while (items < 1900) begin
      r = $urandom_range(0, 7);
      w_raw = (r == 0) ? 0 : (r == 1) ? $urandom_range(1025, 2047) : $urandom_range(1, 20);
      r = $urandom_range(0, 11);
      n_raw = (r == 0) ? 0 : (r == 1) ? $urandom_range(9, 15) : $urandom_range(1, 8);
      set_regs(w_raw, n_raw, pick_coef(), pick_coef(), pick_coef(), pick_coef());
      quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 3))
        send_frame($urandom_range(1, cur_n + 4),
                   $urandom_range(1, (cur_w < 24) ? cur_w : 24), 1);
      quiet = 0;
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/sgb_pkg.sv
src/sgb_queue.sv
src/sgb_front.sv
src/sgb_back.sv
src/separable_gaussian_blur.sv
dv/separable_gaussian_blur_chk.sv
dv/separable_gaussian_blur_tb.sv
